// ----- sv/otsp_pkg.sv -----
// Shared types and constants for the one-shot timer slot pool.
// No dependencies; imported by every module of the block.
package otsp_pkg;

  localparam int CNT_W       = 32;
  localparam int HND_W       = 16;
  localparam int SID_W       = 8;
  localparam int OSLOT_W     = 4;
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Input word kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_REG   = 2'd1;
  localparam logic [1:0] KIND_UNREG = 2'd2;

  // Result word kinds
  localparam logic [1:0] RES_REG    = 2'd0;
  localparam logic [1:0] RES_UNREG  = 2'd1;
  localparam logic [1:0] RES_EXPIRY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } fsm_t;

  // One slot as stored in the slot memory
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [HND_W-1:0] hnd;
  } slot_entry_t;

  // One result word
  typedef struct packed {
    logic [1:0]         kind;
    logic [OSLOT_W-1:0] slot;
    logic [HND_W-1:0]   hnd;
    logic               ok;
    logic               last;
  } result_t;

endpackage

// ----- sv/otsp_mem.sv -----
// Slot memory: one write port, one read port, registered read data.
// Per-entry valid bits make never-written entries read as a cleared slot.
// Depends on otsp_pkg.
module otsp_mem #(
  parameter int SLOT_COUNT = 16,
  parameter int SLOT_W     = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [SLOT_W-1:0]   wr_addr,
  input  otsp_pkg::slot_entry_t wr_data,
  input  logic                rd_en,
  input  logic [SLOT_W-1:0]   rd_addr,
  output otsp_pkg::slot_entry_t rd_data
);
  import otsp_pkg::*;

  slot_entry_t           mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld_r;
  slot_entry_t           rd_data_r;

  // Valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Storage and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/otsp_outreg.sv -----
// Output register for result words; decouples the sequencer from out_stall.
// Depends on otsp_pkg.
module otsp_outreg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  otsp_pkg::result_t load_data,
  output logic             free,
  input  logic             out_stall,
  output logic             out_valid,
  output otsp_pkg::result_t out_data
);
  import otsp_pkg::*;

  logic    valid_r;
  result_t data_r;

  // Room for a new word when empty or when the held word leaves this edge
  assign free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- sv/oneshot_timer_slot_pool_core.sv -----
// One-shot timer slot pool, top level: sequencer plus slot memory and output register.
// Depends on otsp_pkg, otsp_mem, otsp_outreg.
//
// Input channel (in_*): one word per accepted valid & !stall. Kind tick counts
// every nonzero slot down and emits one expiry word per slot that reaches zero
// with a handler, up to MAX_RESULTS; kind register claims the lowest free slot
// and answers with it; kind unregister clears a slot and answers; kind 3 is
// dropped silently. Result channel (out_*): words in order, out_last set on the
// final word of an input word. A quiet tick gives no word.
// Timing: tick and register walk the slot memory one slot per cycle through its
// single read port; a register stops at the first free slot.
// One input word at a time. in_stall is high while a word is in progress.
// A stalled receiver holds the output register; the slot walk pauses only when a
// new expiry word finds both the pending word and the output register full.
// Reset clears all slots (per-slot valid bits, no clearing pass) and all control.
module oneshot_timer_slot_pool_core #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_kind,
  input  logic [otsp_pkg::CNT_W-1:0]    in_delay_ticks,
  input  logic [otsp_pkg::HND_W-1:0]    in_handler,
  input  logic [otsp_pkg::SID_W-1:0]    in_slot_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_result_kind,
  output logic [otsp_pkg::OSLOT_W-1:0]  out_slot,
  output logic [otsp_pkg::HND_W-1:0]    out_fired_handler,
  output logic                          out_ok,
  output logic                          out_last
);
  import otsp_pkg::*;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  fsm_t                 state_r, state_nxt;
  logic [SLOT_W-1:0]    idx_r, idx_nxt;
  logic [RES_CNT_W-1:0] n_r, n_nxt;
  logic                 mode_reg_r, mode_reg_nxt;
  logic [CNT_W-1:0]     delay_r, delay_nxt;
  logic [HND_W-1:0]     hnd_r, hnd_nxt;
  result_t              pend_r, pend_nxt;
  logic                 pend_valid_r, pend_valid_nxt;

  logic                 rd_en, wr_en;
  logic [SLOT_W-1:0]    rd_addr, wr_addr;
  slot_entry_t          rd_data, wr_data;
  logic                 out_load, out_free;
  result_t              out_data, out_word;

  logic                 idx_last, fire, emit, slot_free, sid_ok;
  logic [7:0]           idx_ext;
  logic [CNT_W-1:0]     cnt_dec;

  // Slot storage
  otsp_mem #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_W     (SLOT_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result output register
  otsp_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .load_data (out_data),
    .free      (out_free),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_word)
  );

  assign out_result_kind   = out_word.kind;
  assign out_slot          = out_word.slot;
  assign out_fired_handler = out_word.hnd;
  assign out_ok            = out_word.ok;
  assign out_last          = out_word.last;

  // Per-slot decode of the entry just read
  assign idx_last  = (idx_r == SLOT_W'(SLOT_COUNT - 1));
  assign idx_ext   = 8'(idx_r);
  assign cnt_dec   = rd_data.cnt - CNT_W'(1);
  assign fire      = (rd_data.cnt == CNT_W'(1)) && (rd_data.hnd != '0);
  assign emit      = fire && (n_r < RES_CNT_W'(MAX_RESULTS));
  assign slot_free = (rd_data.cnt == '0) && (rd_data.hnd == '0);
  assign sid_ok    = (in_slot_id < SID_W'(SLOT_COUNT));

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    mode_reg_nxt   = mode_reg_r;
    delay_nxt      = delay_r;
    hnd_nxt        = hnd_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = '0;
    out_load       = 1'b0;
    out_data       = pend_r;
    in_stall       = (state_r != ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            KIND_TICK, KIND_REG: begin
              mode_reg_nxt = (in_kind == KIND_REG);
              delay_nxt    = in_delay_ticks;
              hnd_nxt      = in_handler;
              n_nxt        = '0;
              idx_nxt      = '0;
              rd_en        = 1'b1;
              rd_addr      = '0;
              state_nxt    = ST_SCAN;
            end
            KIND_UNREG: begin
              wr_en          = sid_ok;
              wr_addr        = in_slot_id[SLOT_W-1:0];
              wr_data        = '0;
              pend_nxt.kind  = RES_UNREG;
              pend_nxt.slot  = sid_ok ? in_slot_id[OSLOT_W-1:0] : '0;
              pend_nxt.hnd   = '0;
              pend_nxt.ok    = sid_ok;
              pend_nxt.last  = 1'b0;
              pend_valid_nxt = 1'b1;
              state_nxt      = ST_FLUSH;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (mode_reg_r) begin
          // Search for the lowest free slot
          if (slot_free || idx_last) begin
            wr_en          = slot_free;
            wr_data.cnt    = delay_r;
            wr_data.hnd    = hnd_r;
            pend_nxt.kind  = RES_REG;
            pend_nxt.slot  = slot_free ? idx_ext[OSLOT_W-1:0] : '0;
            pend_nxt.hnd   = '0;
            pend_nxt.ok    = slot_free;
            pend_nxt.last  = 1'b0;
            pend_valid_nxt = 1'b1;
            state_nxt      = ST_FLUSH;
          end else begin
            idx_nxt = idx_r + SLOT_W'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r + SLOT_W'(1);
          end
        end else if (!emit || !pend_valid_r || out_free) begin
          // Tick: count down, fire and free on reaching zero
          wr_en       = (rd_data.cnt != '0);
          wr_data.cnt = cnt_dec;
          wr_data.hnd = (rd_data.cnt == CNT_W'(1)) ? '0 : rd_data.hnd;
          if (emit) begin
            out_load       = pend_valid_r;
            out_data       = pend_r;
            out_data.last  = 1'b0;
            pend_nxt.kind  = RES_EXPIRY;
            pend_nxt.slot  = idx_ext[OSLOT_W-1:0];
            pend_nxt.hnd   = rd_data.hnd;
            pend_nxt.ok    = 1'b1;
            pend_nxt.last  = 1'b0;
            pend_valid_nxt = 1'b1;
            n_nxt          = n_r + RES_CNT_W'(1);
          end
          if (idx_last) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt = idx_r + SLOT_W'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r + SLOT_W'(1);
          end
        end
      end

      ST_FLUSH: begin
        // Hand the final word over, marked last
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_load       = 1'b1;
          out_data       = pend_r;
          out_data.last  = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      n_r          <= '0;
      mode_reg_r   <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      n_r          <= n_nxt;
      mode_reg_r   <= mode_reg_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    delay_r <= delay_nxt;
    hnd_r   <= hnd_nxt;
    pend_r  <= pend_nxt;
  end

  // No pending word survives into idle
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_valid_r)
    else $error("pending result left over in idle");

  // Expiry count never passes the result limit
  a_n_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= RES_CNT_W'(MAX_RESULTS))
    else $error("expiry count above limit");

  // An accepted tick starts the walk at slot zero
  a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_kind == KIND_TICK))
      |=> (state_r == ST_SCAN && idx_r == '0 && !mode_reg_r))
    else $error("tick did not start slot walk");

endmodule
